// ===== sv/gn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// gn2d_pkg: shared constants and helpers for 2d gradient noise
// fixed-point format defaults, command codes and arithmetic helpers
// ----------------------------------------------------------------------------
`default_nettype none
package gn2d_pkg;
   localparam int TABLE_SIZE     = 256;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_W        = 24;
   localparam int OUT_W          = 18;
   localparam int IDX_W          = 8;
   localparam int VAL_W          = 8;

   typedef enum logic {CMD_LOAD = 1'b0, CMD_EVAL = 1'b1} cmd_type;

   // floor((v + 2^(sh-1)) / 2^sh) on a 64-bit signed value
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
      logic signed [63:0] w;
      w = v + (64'sd1 <<< (sh - 1));
      return w >>> sh;
   endfunction

   // signed 32 x 32 product, full width
   function automatic logic signed [63:0] mul_wide(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction
endpackage
`default_nettype wire

// ===== sv/gn2d_core.sv =====
// ----------------------------------------------------------------------------
// gn2d_core: fade and blend datapath
// turns fractions and four corner hashes into the final noise value
// ----------------------------------------------------------------------------
`default_nettype none
module gn2d_core #(
   parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       in_vld,
   input  wire logic [FRAC_BITS-1:0]       xf,
   input  wire logic [FRAC_BITS-1:0]       yf,
   input  wire logic [1:0]                 h_bl,
   input  wire logic [1:0]                 h_tl,
   input  wire logic [1:0]                 h_br,
   input  wire logic [1:0]                 h_tr,
   output logic                            out_vld,
   output logic signed [gn2d_pkg::OUT_W-1:0] out_val
);
   localparam int DW = FRAC_BITS + 3;
   localparam int NS = 6;
   localparam int DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic signed [DW-1:0] SCALE = DW'(1) <<< FRAC_BITS;

   logic [NS-1:0] vld_ff;
   logic signed [DW-1:0] x_ff [2], y_ff [2];
   logic signed [DW-1:0] dbl_ff [4], dtl_ff [4], dbr_ff [4], dtr_ff [4];
   logic signed [31:0] x2_ff, y2_ff, x3_ff, y3_ff, xin_ff, yin_ff, u_ff, v_ff, u2_ff;
   logic signed [31:0] l_ff, r_ff, res_ff;
   logic signed [31:0] xs, ys;
   logic signed [DW-1:0] xd, yd;

   function automatic logic signed [DW-1:0] dot(input logic [1:0] h,
                                                input logic signed [DW-1:0] dx,
                                                input logic signed [DW-1:0] dy);
      case (h)
         2'd0: return dx + dy;
         2'd1: return -dx + dy;
         2'd2: return -dx - dy;
         default: return dx - dy;
      endcase
   endfunction

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], in_vld};
   end
   assign out_vld = vld_ff[NS-1];

   assign xd = DW'({1'b0, xf});
   assign yd = DW'({1'b0, yf});
   assign xs = 32'(x_ff[1]);
   assign ys = 32'(y_ff[1]);

   // dots in stage 1 and delayed to the y lerp, fade in stages 2..4, lerps in 5..6
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= xd;
         y_ff[0] <= yd;
         x_ff[1] <= x_ff[0];
         y_ff[1] <= y_ff[0];
         dbl_ff[0] <= dot(h_bl, xd, yd);
         dtl_ff[0] <= dot(h_tl, xd, yd - SCALE);
         dbr_ff[0] <= dot(h_br, xd - SCALE, yd);
         dtr_ff[0] <= dot(h_tr, xd - SCALE, yd - SCALE);
         for (int i = 1; i < 4; i++) begin
            dbl_ff[i] <= dbl_ff[i-1];
            dtl_ff[i] <= dtl_ff[i-1];
            dbr_ff[i] <= dbr_ff[i-1];
            dtr_ff[i] <= dtr_ff[i-1];
         end
         // stage 2: t^2
         x2_ff <= 32'(gn2d_pkg::round_shift(
                  gn2d_pkg::mul_wide(32'(x_ff[0]), 32'(x_ff[0])), FRAC_BITS));
         y2_ff <= 32'(gn2d_pkg::round_shift(
                  gn2d_pkg::mul_wide(32'(y_ff[0]), 32'(y_ff[0])), FRAC_BITS));
         // stage 3: t^3 and inner polynomial
         x3_ff  <= 32'(gn2d_pkg::round_shift(gn2d_pkg::mul_wide(x2_ff, xs), FRAC_BITS));
         y3_ff  <= 32'(gn2d_pkg::round_shift(gn2d_pkg::mul_wide(y2_ff, ys), FRAC_BITS));
         xin_ff <= (32'sd10 <<< FRAC_BITS) - 32'sd15 * xs + 32'sd6 * x2_ff;
         yin_ff <= (32'sd10 <<< FRAC_BITS) - 32'sd15 * ys + 32'sd6 * y2_ff;
         // stage 4: fade
         u_ff <= 32'(gn2d_pkg::round_shift(gn2d_pkg::mul_wide(x3_ff, xin_ff), FRAC_BITS));
         v_ff <= 32'(gn2d_pkg::round_shift(gn2d_pkg::mul_wide(y3_ff, yin_ff), FRAC_BITS));
         // stage 5: lerp along y
         u2_ff <= u_ff;
         l_ff <= 32'(dbl_ff[3]) + 32'(gn2d_pkg::round_shift(
                 gn2d_pkg::mul_wide(v_ff, 32'(dtl_ff[3]) - 32'(dbl_ff[3])), FRAC_BITS));
         r_ff <= 32'(dbr_ff[3]) + 32'(gn2d_pkg::round_shift(
                 gn2d_pkg::mul_wide(v_ff, 32'(dtr_ff[3]) - 32'(dbr_ff[3])), FRAC_BITS));
         // stage 6: lerp along x
         res_ff <= l_ff + 32'(gn2d_pkg::round_shift(
                   gn2d_pkg::mul_wide(u2_ff, r_ff - l_ff), FRAC_BITS));
      end
   end

   // scale to 16 fraction bits and saturate
   always_comb begin
      logic signed [63:0] s;
      s = (DN > 0) ? gn2d_pkg::round_shift(64'(res_ff), DN) : (64'(res_ff) <<< UP);
      if (s > 64'sd131071) out_val = 18'sd131071;
      else if (s < -64'sd131072) out_val = -18'sd131072;
      else out_val = s[gn2d_pkg::OUT_W-1:0];
   end
endmodule
`default_nettype wire

// ===== sv/gradient_noise_2d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_2d: two-dimensional improved gradient noise
// permutation table in memory, hash lookups, fade and lerp pipeline
// ----------------------------------------------------------------------------
// Use: items arrive on req_ (valid/ready). cmd 0 writes perm entry
// req_table_index with req_table_value and produces no result. cmd 1
// evaluates noise at (req_coord_x, req_coord_y), Q8.16, giving one result on
// rsp_noise_value (signed Q2.16, saturated).
// Throughput: one item per cycle while rsp_ is not stalled. The table is kept
// in three copies, each read at two addresses per cycle: one for the cell row,
// two for the four corner hashes. An accepted evaluate passes through 2 table
// read stages and 6 datapath stages; the last one is the output.
// A load is written at its acceptance edge, so every later evaluate sees it
// and every earlier one still reads the old entry.
// Reset clears the pipeline valids only; table entries are undefined until
// written, and req_ready is low while reset is high. When the receiver stalls
// rsp_ the entire pipe holds and req_ready falls while the output register
// is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none
module gradient_noise_2d #(
   parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_cmd,
   input  wire logic [gn2d_pkg::IDX_W-1:0]          req_table_index,
   input  wire logic [gn2d_pkg::VAL_W-1:0]          req_table_value,
   input  wire logic [gn2d_pkg::COORD_W-1:0]        req_coord_x,
   input  wire logic [gn2d_pkg::COORD_W-1:0]        req_coord_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [gn2d_pkg::OUT_W-1:0]        rsp_noise_value
);
   localparam int AW = $clog2(gn2d_pkg::TABLE_SIZE);

   logic [gn2d_pkg::VAL_W-1:0] mem_row [gn2d_pkg::TABLE_SIZE];
   logic [gn2d_pkg::VAL_W-1:0] mem_lft [gn2d_pkg::TABLE_SIZE];
   logic [gn2d_pkg::VAL_W-1:0] mem_rgt [gn2d_pkg::TABLE_SIZE];
   logic adv, acc, wr;
   logic [AW-1:0] waddr;

   logic                 s1_ff, s2_ff;
   logic [AW-1:0]        yi1_ff;
   logic [FRAC_BITS-1:0] xf1_ff, yf1_ff, xf2_ff, yf2_ff;
   logic [gn2d_pkg::VAL_W-1:0] px_ff, pxn_ff, hbl_ff, htl_ff, hbr_ff, htr_ff;
   logic [AW-1:0] xi, xn, a_bl, a_tl, a_br, a_tr;
   logic core_vld;
   logic signed [gn2d_pkg::OUT_W-1:0] core_val;

   // pipe advances unless result register is held
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv && !reset;
   assign acc = req_valid && req_ready;
   assign wr  = acc && (req_cmd == gn2d_pkg::CMD_LOAD);
   assign waddr = AW'(req_table_index);

   assign xi = AW'(req_coord_x >> FRAC_BITS);
   assign xn = xi + AW'(1);

   // table copy for the cell row: write and first read
   always_ff @(posedge clock) begin
      if (wr) mem_row[waddr] <= req_table_value;
      if (adv) begin
         px_ff  <= mem_row[xi];
         pxn_ff <= mem_row[xn];
      end
   end

   // first stage coordinates
   always_ff @(posedge clock) begin
      if (adv) begin
         yi1_ff <= AW'(req_coord_y >> FRAC_BITS);
         xf1_ff <= req_coord_x[FRAC_BITS-1:0];
         yf1_ff <= req_coord_y[FRAC_BITS-1:0];
      end
   end

   assign a_bl = AW'(px_ff) + yi1_ff;
   assign a_tl = AW'(px_ff) + yi1_ff + AW'(1);
   assign a_br = AW'(pxn_ff) + yi1_ff;
   assign a_tr = AW'(pxn_ff) + yi1_ff + AW'(1);

   // table copy for the left corner hashes
   always_ff @(posedge clock) begin
      if (wr) mem_lft[waddr] <= req_table_value;
      if (adv) begin
         hbl_ff <= mem_lft[a_bl];
         htl_ff <= mem_lft[a_tl];
      end
   end

   // table copy for the right corner hashes
   always_ff @(posedge clock) begin
      if (wr) mem_rgt[waddr] <= req_table_value;
      if (adv) begin
         hbr_ff <= mem_rgt[a_br];
         htr_ff <= mem_rgt[a_tr];
      end
   end

   // second stage fractions
   always_ff @(posedge clock) begin
      if (adv) begin
         xf2_ff <= xf1_ff;
         yf2_ff <= yf1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else if (adv) begin
         s1_ff <= acc && (req_cmd == gn2d_pkg::CMD_EVAL);
         s2_ff <= s1_ff;
      end
   end

   gn2d_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(s2_ff),
      .xf(xf2_ff), .yf(yf2_ff),
      .h_bl(hbl_ff[1:0]), .h_tl(htl_ff[1:0]), .h_br(hbr_ff[1:0]), .h_tr(htr_ff[1:0]),
      .out_vld(core_vld), .out_val(core_val)
   );

   assign rsp_valid       = core_vld;
   assign rsp_noise_value = core_val;

   // pipe must hold while result is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while stalled");
   a_load: assert property (@(posedge clock) disable iff (reset)
      wr |=> !s1_ff)
      else $error("load started an evaluation");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for gradient_noise_2d
// fills the permutation table, walks a directed stimulus table, then sends
// random load and evaluate items with random idling on both channels; every
// result is checked in order against a fixed-point noise predictor
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC     = 16;
   localparam int CELLS    = 256;
   localparam int N_RANDOM = 230;
   localparam int LIMIT    = 200000;
   localparam int TAIL     = 24;

   // one row of directed stimulus
   typedef struct {
      gn2d_pkg::cmd_type               cmd;
      logic [gn2d_pkg::IDX_W-1:0]      index;
      logic [gn2d_pkg::VAL_W-1:0]      value;
      logic [gn2d_pkg::COORD_W-1:0]    x;
      logic [gn2d_pkg::COORD_W-1:0]    y;
      bit                              known;
      int                              noise;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   gn2d_pkg::cmd_type req_cmd = gn2d_pkg::CMD_LOAD;
   logic [gn2d_pkg::IDX_W-1:0] req_table_index = '0;
   logic [gn2d_pkg::VAL_W-1:0] req_table_value = '0;
   logic [gn2d_pkg::COORD_W-1:0] req_coord_x = '0;
   logic [gn2d_pkg::COORD_W-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [gn2d_pkg::OUT_W-1:0] rsp_noise_value;

   logic [gn2d_pkg::VAL_W-1:0] perm_copy [CELLS];
   logic signed [gn2d_pkg::OUT_W-1:0] noise_due [$];
   int   fail_count = 0;
   int   cycle_count = 0;
   bit   quiet = 1'b0;
   bit   hold_request = 1'b0;

   stim_row_type directed [] = '{
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h000000, 24'h000000, 1'b1, 0},
      '{gn2d_pkg::CMD_LOAD, 8'd255, 8'd255, 24'h000000, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_LOAD, 8'd0,   8'd0,   24'h000000, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'hFF0000, 24'hFF0000, 1'b1, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'hFF0000, 24'h010000, 1'b1, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'hFFFFFF, 24'hFFFFFF, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h00FFFF, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h000000, 24'h00FFFF, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h008000, 24'h008000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'hFF8000, 24'h7F4000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h000001, 24'h000001, 1'b0, 0},
      '{gn2d_pkg::CMD_LOAD, 8'd128, 8'd1,   24'h000000, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_LOAD, 8'd1,   8'd2,   24'h000000, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_LOAD, 8'd2,   8'd3,   24'h000000, 24'h000000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h804000, 24'h01C000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h01C000, 24'h02C000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h7FFFFF, 24'h800000, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'hAAAAAA, 24'h555555, 1'b0, 0},
      '{gn2d_pkg::CMD_EVAL, 8'd0,   8'd0,   24'h555555, 24'hAAAAAA, 1'b0, 0}
   };

   gradient_noise_2d DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_table_index(req_table_index), .req_table_value(req_table_value),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor((v + half) / 2^FRAC)
   function automatic longint fix_round(input longint v);
      return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint fade_of(input longint t);
      longint t2, t3, inner;
      t2 = fix_round(t * t);
      inner = 10 * (longint'(1) <<< FRAC) - 15 * t + 6 * t2;
      t3 = fix_round(t2 * t);
      return fix_round(t3 * inner);
   endfunction

   function automatic longint gradient_dot(input logic [gn2d_pkg::VAL_W-1:0] hash,
                                           input longint dx, input longint dy);
      case (hash[1:0])
         2'd0: return dx + dy;
         2'd1: return -dx + dy;
         2'd2: return -dx - dy;
         default: return dx - dy;
      endcase
   endfunction

   // expected noise at a point, from the bench's copy of the table
   function automatic logic signed [gn2d_pkg::OUT_W-1:0] noise_at(
         input logic [gn2d_pkg::COORD_W-1:0] x,
         input logic [gn2d_pkg::COORD_W-1:0] y);
      logic [7:0] xi, yi, xn, yn, px, pxn;
      longint xf, yf, s, u, v, left, right, r;
      s  = longint'(1) <<< FRAC;
      xi = x[gn2d_pkg::COORD_W-1:FRAC];
      yi = y[gn2d_pkg::COORD_W-1:FRAC];
      xn = xi + 8'd1;
      yn = yi + 8'd1;
      xf = longint'(x[FRAC-1:0]);
      yf = longint'(y[FRAC-1:0]);
      px  = perm_copy[xi];
      pxn = perm_copy[xn];
      u = fade_of(xf);
      v = fade_of(yf);
      left  = gradient_dot(perm_copy[8'(px + yi)], xf, yf);
      left  = left + fix_round(v * (gradient_dot(perm_copy[8'(px + yn)], xf, yf - s) - left));
      right = gradient_dot(perm_copy[8'(pxn + yi)], xf - s, yf);
      right = right + fix_round(v *
              (gradient_dot(perm_copy[8'(pxn + yn)], xf - s, yf - s) - right));
      r = left + fix_round(u * (right - left));
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return gn2d_pkg::OUT_W'(r);
   endfunction

   // offer one item, with an optional idle burst first; update the table copy
   // and the expected results on acceptance
   task automatic offer_item(input gn2d_pkg::cmd_type cmd,
                             input logic [gn2d_pkg::IDX_W-1:0] index,
                             input logic [gn2d_pkg::VAL_W-1:0] value,
                             input logic [gn2d_pkg::COORD_W-1:0] x,
                             input logic [gn2d_pkg::COORD_W-1:0] y,
                             input bit known, input int noise);
      logic signed [gn2d_pkg::OUT_W-1:0] due;
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_table_index = index;
      req_table_value = value;
      req_coord_x = x;
      req_coord_y = y;
      do @(posedge clock); while (!req_ready);
      if (cmd == gn2d_pkg::CMD_LOAD) begin
         perm_copy[index] = value;
      end else begin
         due = noise_at(x, y);
         if (known && due !== gn2d_pkg::OUT_W'(noise)) begin
            $error("directed row mismatch: noise_value expected %0d predicted %0d",
                   noise, due);
            fail_count++;
         end
         noise_due.push_back(due);
      end
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid = 1'b0;
      while (noise_due.size() != 0) @(posedge clock);
   endtask

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random idle bursts, one long hold-off on request
   initial begin
      int burst;
      int held;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            held = 0;
            while (held < 300) begin
               @(negedge clock);
               held++;
            end
            hold_request = 1'b0;
            rsp_ready = 1'b1;
         end else if (quiet) begin
            rsp_ready = 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_ready = 1'b0;
         end else if ($urandom_range(3) == 0) begin
            burst = $urandom_range(1, 6) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      logic signed [gn2d_pkg::OUT_W-1:0] due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_due.size() == 0) begin
            $error("unexpected result: noise_value %0d", rsp_noise_value);
            fail_count++;
         end else begin
            due = noise_due.pop_front();
            if (rsp_noise_value !== due) begin
               $error("noise_value expected %0d actual %0d", due, rsp_noise_value);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int i;
      gn2d_pkg::cmd_type cmd;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // whole table written before any evaluate reads it
      for (i = 0; i < CELLS; i++)
         offer_item(gn2d_pkg::CMD_LOAD, gn2d_pkg::IDX_W'(i), gn2d_pkg::VAL_W'(i),
                    '0, '0, 1'b0, 0);
      for (i = 0; i < directed.size(); i++)
         offer_item(directed[i].cmd, directed[i].index, directed[i].value,
                    directed[i].x, directed[i].y, directed[i].known, directed[i].noise);
      pause_sender();

      // random loads and evaluates
      for (i = 0; i < N_RANDOM; i++) begin
         if (i == 60) hold_request = 1'b1;
         if (i == 130) pause_sender();
         if (i == N_RANDOM - 60) quiet = 1'b1;
         cmd = ($urandom_range(3) == 0) ? gn2d_pkg::CMD_LOAD : gn2d_pkg::CMD_EVAL;
         offer_item(cmd, gn2d_pkg::IDX_W'($urandom), gn2d_pkg::VAL_W'($urandom),
                    gn2d_pkg::COORD_W'($urandom), gn2d_pkg::COORD_W'($urandom), 1'b0, 0);
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (noise_due.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (fail_count == 0 && noise_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
